### hdl/wto_pkg.sv
// wavetable oscillator package: sizes, fixed-point types, register and waveform codes
// also holds the elaboration-time sine table builder and the computed waveform shapes
// no dependencies
package wto_pkg;

    // table geometry and phase format
    localparam int TABLE_SIZE = 1024;
    localparam int FRAC_BITS  = 31;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int PHASE_W    = IDX_W + FRAC_BITS;
    localparam int SAMPLE_W   = 32;
    localparam int CFG_W      = PHASE_W;
    localparam int CFG_IDX_W  = 2;

    // interpolation widths
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    // computed shape helpers
    localparam int QUARTER   = TABLE_SIZE / 4;
    localparam int HALF      = TABLE_SIZE / 2;
    localparam int D_W       = IDX_W + 2;
    localparam int TRI_SHIFT = SAMPLE_W + 1 - IDX_W;
    localparam int SAW_SHIFT = SAMPLE_W - IDX_W;
    localparam int WIDE_W    = D_W + TRI_SHIFT;

    // sine series constants
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned WORD_MASK   = 64'hFFFF_FFFF;
    localparam longint          Q31_MAX     = 64'sd2147483647;

    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [FRAC_BITS-1:0]        frac_t;
    typedef logic [PHASE_W-1:0]          phase_t;
    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef sample_t                     sine_rom_t [TABLE_SIZE];

    localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_SQUARE   = 2'd3
    } wave_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVEFORM  = 2'd0,
        REG_PHASE_INC = 2'd1,
        REG_PHASE_OFS = 2'd2
    } reg_index_t;

    // shift-subtract quotient for the series denominators
    function automatic longint unsigned series_quotient(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int bit_pos = 63; bit_pos >= 0; bit_pos--)
        begin
            rem = {rem[62:0], num[bit_pos]};
            if (rem >= den)
            begin
                rem          = rem - den;
                quo[bit_pos] = 1'b1;
            end
        end
        return quo;
    endfunction

    // one sine entry: quarter-wave folding and a ten-term taylor series in q30
    function automatic sample_t sine_entry(input int unsigned i);
        longint unsigned a;
        longint unsigned r;
        longint unsigned t;
        longint unsigned x;
        longint unsigned m;
        longint unsigned q;
        longint          s;
        a = ((longint'(i) << 32) / TABLE_SIZE) & WORD_MASK;
        q = a >> 30;
        r = a & (Q30_ONE - 64'd1);
        t = q[0] ? (Q30_ONE - r) : r;
        x = (t * HALF_PI_Q30) >> 30;
        m = x;
        s = longint'(x);
        for (int unsigned k = 1; k <= 9; k++) begin
            m = (((m * x) >> 30) * x) >> 30;
            m = series_quotient(m, 64'((2 * k) * (2 * k + 1)));
            if (k[0])
                s = s - longint'(m);
            else
                s = s + longint'(m);
        end
        if (s < 0)
            s = 0;
        s = s * 2;
        if (s > Q31_MAX)
            s = Q31_MAX;
        if (q >= 64'd2)
            s = -s;
        return sample_t'(s);
    endfunction

    // whole sine table, evaluated at elaboration
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    // clamp a widened value into q31
    function automatic sample_t sat_sample(input logic signed [WIDE_W-1:0] wide);
        sample_t val;
        if (wide > WIDE_W'(SAMPLE_MAX))
            val = SAMPLE_MAX;
        else if (wide < WIDE_W'(SAMPLE_MIN))
            val = SAMPLE_MIN;
        else
            val = wide[SAMPLE_W-1:0];
        return val;
    endfunction

    // table entry for any waveform; the sine value comes from the rom read
    function automatic sample_t shape_entry(input wave_t wave, input idx_t idx,
                                            input sample_t sine);
        logic signed [D_W-1:0]    idx_s;
        logic signed [D_W-1:0]    d;
        logic signed [WIDE_W-1:0] wide;
        sample_t                  val;
        idx_s = $signed({2'b00, idx});
        d     = '0;
        wide  = '0;
        unique case (wave)
            WAVE_SINE: begin
                val = sine;
            end
            WAVE_TRIANGLE: begin
                if (idx < idx_t'(QUARTER))
                    d = idx_s;
                else if (idx < idx_t'(3 * QUARTER))
                    d = D_W'(HALF) - idx_s;
                else
                    d = idx_s - D_W'(TABLE_SIZE);
                wide = WIDE_W'(d) <<< TRI_SHIFT;
                val  = sat_sample(wide);
            end
            WAVE_SAW: begin
                d    = idx_s - D_W'(HALF);
                wide = WIDE_W'(d) <<< SAW_SHIFT;
                val  = sat_sample(wide);
            end
            WAVE_SQUARE: begin
                val = (idx < idx_t'(HALF)) ? SAMPLE_MAX : SAMPLE_MIN;
            end
        endcase
        return val;
    endfunction

endpackage

### hdl/wavetable_oscillator_core.sv
// wavetable oscillator with linear interpolation between adjacent table entries
// depends on wto_pkg (types, codes, sine table builder, computed shapes)
// an accepted sample request reaches its result beat through the stage a, stage b and output registers
// throughput: one request per cycle; the three-stage pipe (rom read, multiply, add)
// stalls only when all stages are full and the output beat is held
// reset: phase, waveform, increment and offset cleared; all stages empty
module wavetable_oscillator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic                              end_of_block,
    output logic                              out_valid,
    input  logic                              out_stall,
    output wto_pkg::sample_t                  sample,
    output logic                              last_in_block,
    input  logic                              cfg_write_en,
    input  logic [wto_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wto_pkg::CFG_W-1:0]         cfg_data
);
    import wto_pkg::*;

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // configuration
    wave_t  waveform_reg;
    phase_t phase_inc_reg;
    phase_t phase_ofs_reg;

    // phase accumulator
    phase_t phase_reg;
    phase_t phase_next;
    phase_t phase_sum;

    // pipeline control
    logic out_ready;
    logic b_ready;
    logic a_ready;
    logic in_accept;
    logic sample_req;
    idx_t cur_idx;
    idx_t nxt_idx;

    // stage a: rom read
    logic    a_valid_reg;
    logic    a_valid_next;
    logic    a_last_reg;
    idx_t    a_idx_reg;
    idx_t    a_nidx;
    frac_t   a_frac_reg;
    sample_t a_sin_cur_reg;
    sample_t a_sin_nxt_reg;

    // stage b: difference and product
    logic                     b_valid_reg;
    logic                     b_valid_next;
    logic                     b_last_reg;
    sample_t                  b_cur_reg;
    sample_t                  b_prod_reg;
    sample_t                  b_cur;
    sample_t                  b_nxt;
    logic signed [DIFF_W-1:0] b_diff;
    logic signed [PROD_W-1:0] b_prod;
    logic signed [SAMPLE_W:0] b_frac_s;

    // output register
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_last_reg;
    sample_t sample_reg;
    sample_t sample_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= WAVE_SINE;
            phase_inc_reg <= '0;
            phase_ofs_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_WAVEFORM:  waveform_reg  <= wave_t'(cfg_data[1:0]);
                REG_PHASE_INC: phase_inc_reg <= cfg_data;
                REG_PHASE_OFS: phase_ofs_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // backpressure through the stages
    assign out_ready  = !out_valid_reg || !out_stall;
    assign b_ready    = !b_valid_reg || out_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign in_stall   = !a_ready;
    assign in_accept  = in_valid && a_ready;
    assign sample_req = in_accept && !action;

    // phase advance or restart; wraps at the table span
    assign phase_sum = phase_reg + phase_inc_reg;
    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
            phase_next = action ? phase_ofs_reg : phase_sum;
    end

    assign cur_idx = phase_reg[PHASE_W-1:FRAC_BITS];
    assign nxt_idx = cur_idx + idx_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

    // stage valid bits
    assign a_valid_next   = a_ready ? sample_req : a_valid_reg;
    assign b_valid_next   = b_ready ? a_valid_reg : b_valid_reg;
    assign out_valid_next = out_ready ? b_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage a payload: sine rom read at both neighbors
    always_ff @(posedge clk)
    begin
        if (sample_req)
        begin
            a_idx_reg     <= cur_idx;
            a_frac_reg    <= phase_reg[FRAC_BITS-1:0];
            a_last_reg    <= end_of_block;
            a_sin_cur_reg <= SINE_ROM[cur_idx];
            a_sin_nxt_reg <= SINE_ROM[nxt_idx];
        end
    end

    // stage b: pick entries, difference times fraction
    assign a_nidx   = a_idx_reg + idx_t'(1);
    assign b_cur    = shape_entry(waveform_reg, a_idx_reg, a_sin_cur_reg);
    assign b_nxt    = shape_entry(waveform_reg, a_nidx, a_sin_nxt_reg);
    assign b_diff   = DIFF_W'(b_nxt) - DIFF_W'(b_cur);
    assign b_frac_s = $signed({{(SAMPLE_W + 1 - FRAC_BITS){1'b0}}, a_frac_reg});
    assign b_prod   = PROD_W'(b_diff) * PROD_W'(b_frac_s);

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_cur_reg  <= b_cur;
            b_prod_reg <= b_prod[FRAC_BITS +: SAMPLE_W];
            b_last_reg <= a_last_reg;
        end
    end

    // output beat: floor-scaled product plus current entry
    assign sample_next = b_cur_reg + b_prod_reg;

    always_ff @(posedge clk)
    begin
        if (out_ready && b_valid_reg)
        begin
            sample_reg   <= sample_next;
            out_last_reg <= b_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign last_in_block = out_last_reg;

    // restart loads the offset and sends nothing down the pipe
    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action) |=> (phase_reg == $past(phase_ofs_reg)))
        else $error("restart did not load phase offset");

    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action) |=> !a_valid_reg)
        else $error("restart produced a pipeline beat");

    // a sample request advances the phase by the increment
    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !action) |=> (phase_reg == $past(phase_sum)))
        else $error("phase did not advance by increment");

    // input stalls only with every stage full and the output held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

endmodule
